[hdl/ptm_pkg.sv]
// Shared types, constants and the sequencer microprogram for the page table mapper.
// Depends on nothing; every other file but ptm_table_ram imports it.
`default_nettype none

package ptm_pkg;

   // Table store geometry.
   localparam int TABLE_PAGES       = 16;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int PAGE_W            = $clog2(TABLE_PAGES);
   localparam int SLOT_W            = PAGE_W + IDX_W;
   localparam int LEVELS            = 4;

   // Address fields.
   localparam int ADDR_W        = 64;
   localparam int BASE_W        = 57;
   localparam int PAGE_OFS_W    = 12;
   localparam int FRAME_W       = BASE_W - PAGE_OFS_W;
   localparam int VIDX_W        = LEVELS * IDX_W;
   localparam int ENTRY_W       = FRAME_W + 1;
   localparam int ARENA_PAGES_W = 5;
   localparam int TABLES_USED_W = 5;
   localparam int PU_W          = $clog2(TABLE_PAGES + 1);
   localparam int CNT_W         = (PU_W > ARENA_PAGES_W) ? PU_W : ARENA_PAGES_W;
   localparam int CSR_IDX_W     = 2;
   localparam int STEP_W        = 5;

   // Low bits of the leaf entry the block reports: present and writable.
   localparam logic [PAGE_OFS_W-1:0] ENTRY_FLAGS = 12'h003;

   // Result status codes.
   localparam logic [1:0] STATUS_MAPPED    = 2'd0;
   localparam logic [1:0] STATUS_RANGE_ERR = 2'd1;
   localparam logic [1:0] STATUS_NO_TABLES = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_PAGES = 2'd1;

   typedef struct packed {
      logic [ADDR_W-1:0] phys_addr;
      logic [ADDR_W-1:0] virt_addr;
   } ptm_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [BASE_W-1:0]        leaf_entry;
      logic [TABLES_USED_W-1:0] tables_used;
   } ptm_rsp_type;

   typedef struct packed {
      logic [BASE_W-1:0]        arena_base;
      logic [ARENA_PAGES_W-1:0] arena_pages;
   } ptm_csr_type;

   // Datapath operations, one per microcode step.
   typedef enum logic [4:0] {
      OP_IDLE        = 5'd0,
      OP_NONE        = 5'd1,
      OP_INIT        = 5'd2,
      OP_READ        = 5'd3,
      OP_CAPTURE     = 5'd4,
      OP_ALLOC       = 5'd5,
      OP_WRITE_ONE   = 5'd6,
      OP_LINK        = 5'd7,
      OP_NEXT_LEVEL  = 5'd8,
      OP_LEAF_SETUP  = 5'd9,
      OP_SWEEP_CLR   = 5'd10,
      OP_SWEEP_WR    = 5'd11,
      OP_ZFLAG_CLR   = 5'd12,
      OP_SET_OK      = 5'd13,
      OP_SET_RANGE   = 5'd14,
      OP_SET_FULL    = 5'd15,
      OP_EMIT        = 5'd16
   } ptm_op_type;

   // Jump conditions.
   typedef enum logic [3:0] {
      C_ALWAYS     = 4'd0,
      C_REQ        = 4'd1,
      C_RANGE_BAD  = 4'd2,
      C_PRESENT    = 4'd3,
      C_NO_ROOM    = 4'd4,
      C_FOREIGN    = 4'd5,
      C_LEAF       = 4'd6,
      C_PAGE_ZERO  = 4'd7,
      C_SWEEP_LAST = 4'd8,
      C_OUT_BUSY   = 4'd9
   } ptm_cond_type;

   typedef struct packed {
      ptm_op_type        op;
      ptm_cond_type      cond;
      logic              jump_on;
      logic [STEP_W-1:0] target;
   } ptm_ctl_type;

   typedef struct packed {
      logic req_fire;
      logic range_bad;
      logic present;
      logic no_room;
      logic foreign;
      logic leaf;
      logic page_zero;
      logic sweep_last;
      logic out_busy;
   } ptm_flags_type;

   // Step addresses of the microprogram.
   localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
   localparam logic [STEP_W-1:0] S_START  = 5'd1;
   localparam logic [STEP_W-1:0] S_READ   = 5'd2;
   localparam logic [STEP_W-1:0] S_CAPT   = 5'd3;
   localparam logic [STEP_W-1:0] S_TEST   = 5'd4;
   localparam logic [STEP_W-1:0] S_ROOM   = 5'd5;
   localparam logic [STEP_W-1:0] S_ALLOC  = 5'd6;
   localparam logic [STEP_W-1:0] S_WCHK   = 5'd7;
   localparam logic [STEP_W-1:0] S_WONE   = 5'd8;
   localparam logic [STEP_W-1:0] S_WEND   = 5'd9;
   localparam logic [STEP_W-1:0] S_LINK   = 5'd10;
   localparam logic [STEP_W-1:0] S_FCHK   = 5'd11;
   localparam logic [STEP_W-1:0] S_NEXT   = 5'd12;
   localparam logic [STEP_W-1:0] S_NLEAF  = 5'd13;
   localparam logic [STEP_W-1:0] S_LEAF   = 5'd14;
   localparam logic [STEP_W-1:0] S_SWINIT = 5'd15;
   localparam logic [STEP_W-1:0] S_SWEEP  = 5'd16;
   localparam logic [STEP_W-1:0] S_SWEND  = 5'd17;
   localparam logic [STEP_W-1:0] S_OK     = 5'd18;
   localparam logic [STEP_W-1:0] S_RANGE  = 5'd19;
   localparam logic [STEP_W-1:0] S_FULL   = 5'd20;
   localparam logic [STEP_W-1:0] S_EMITW  = 5'd21;
   localparam logic [STEP_W-1:0] S_EMIT   = 5'd22;

   // Microprogram. A step jumps to target when its condition equals jump_on,
   // otherwise it falls through to the next step.
   function automatic ptm_ctl_type ptm_ucode(input logic [STEP_W-1:0] step);
      ptm_ctl_type w;
      case (step)
         S_IDLE:   w = '{OP_IDLE,       C_REQ,        1'b0, S_IDLE};
         S_START:  w = '{OP_INIT,       C_RANGE_BAD,  1'b1, S_RANGE};
         S_READ:   w = '{OP_READ,       C_ALWAYS,     1'b0, S_READ};
         S_CAPT:   w = '{OP_CAPTURE,    C_ALWAYS,     1'b0, S_CAPT};
         S_TEST:   w = '{OP_NONE,       C_PRESENT,    1'b1, S_LINK};
         S_ROOM:   w = '{OP_NONE,       C_NO_ROOM,    1'b1, S_FULL};
         S_ALLOC:  w = '{OP_ALLOC,      C_ALWAYS,     1'b0, S_ALLOC};
         S_WCHK:   w = '{OP_NONE,       C_PAGE_ZERO,  1'b1, S_SWINIT};
         S_WONE:   w = '{OP_WRITE_ONE,  C_ALWAYS,     1'b0, S_WONE};
         S_WEND:   w = '{OP_NONE,       C_LEAF,       1'b1, S_OK};
         S_LINK:   w = '{OP_LINK,       C_ALWAYS,     1'b0, S_LINK};
         S_FCHK:   w = '{OP_NONE,       C_FOREIGN,    1'b1, S_FULL};
         S_NEXT:   w = '{OP_NEXT_LEVEL, C_ALWAYS,     1'b0, S_NEXT};
         S_NLEAF:  w = '{OP_NONE,       C_LEAF,       1'b0, S_READ};
         S_LEAF:   w = '{OP_LEAF_SETUP, C_ALWAYS,     1'b1, S_WCHK};
         S_SWINIT: w = '{OP_SWEEP_CLR,  C_ALWAYS,     1'b0, S_SWINIT};
         S_SWEEP:  w = '{OP_SWEEP_WR,   C_SWEEP_LAST, 1'b0, S_SWEEP};
         S_SWEND:  w = '{OP_ZFLAG_CLR,  C_ALWAYS,     1'b1, S_WEND};
         S_OK:     w = '{OP_SET_OK,     C_ALWAYS,     1'b1, S_EMITW};
         S_RANGE:  w = '{OP_SET_RANGE,  C_ALWAYS,     1'b1, S_EMITW};
         S_FULL:   w = '{OP_SET_FULL,   C_ALWAYS,     1'b0, S_FULL};
         S_EMITW:  w = '{OP_NONE,       C_OUT_BUSY,   1'b1, S_EMITW};
         S_EMIT:   w = '{OP_EMIT,       C_ALWAYS,     1'b1, S_IDLE};
         default:  w = '{OP_NONE,       C_ALWAYS,     1'b1, S_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[hdl/ptm_table_ram.sv]
// Simple dual-port RAM holding the table pages: one write and one registered read per cycle.
// Depends on nothing; sized by its parameters.
`default_nettype none

module ptm_table_ram #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 46
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/ptm_sequencer.sv]
// Microcode sequencer: step counter, program ROM lookup and conditional jump select.
// Depends on ptm_pkg for the control word, the flags and the microprogram.
`default_nettype none

module ptm_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ptm_pkg::ptm_flags_type flags,
   output      ptm_pkg::ptm_ctl_type   ctl
);
   import ptm_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              cond_val;

   assign ctl = ptm_ucode(step_ff);

   always_comb begin
      case (ctl.cond)
         C_ALWAYS:     cond_val = 1'b1;
         C_REQ:        cond_val = flags.req_fire;
         C_RANGE_BAD:  cond_val = flags.range_bad;
         C_PRESENT:    cond_val = flags.present;
         C_NO_ROOM:    cond_val = flags.no_room;
         C_FOREIGN:    cond_val = flags.foreign;
         C_LEAF:       cond_val = flags.leaf;
         C_PAGE_ZERO:  cond_val = flags.page_zero;
         C_SWEEP_LAST: cond_val = flags.sweep_last;
         C_OUT_BUSY:   cond_val = flags.out_busy;
         default:      cond_val = 1'b1;
      endcase
   end

   assign step_in = (cond_val == ctl.jump_on) ? ctl.target : step_ff + STEP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

[hdl/ptm_datapath.sv]
// Walk datapath: request registers, level and page pointers, allocation, page zero flags,
// the table store and the result registers. Depends on ptm_pkg and ptm_table_ram.
`default_nettype none

module ptm_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ptm_pkg::ptm_ctl_type   ctl,
   input  wire logic                   req_fire,
   input  wire ptm_pkg::ptm_req_type   req_data,
   input  wire ptm_pkg::ptm_csr_type   csr,
   input  wire logic                   out_busy,
   output      ptm_pkg::ptm_flags_type flags,
   output      ptm_pkg::ptm_rsp_type   result
);
   import ptm_pkg::*;

   logic [FRAME_W-1:0]     phys_frame_ff;
   logic [VIDX_W-1:0]      vidx_ff;
   logic                   range_bad_ff;
   logic [1:0]             level_ff;
   logic [PAGE_W-1:0]      cur_ff;
   logic [ENTRY_W-1:0]     entry_ff;
   logic [PAGE_W-1:0]      wr_page_ff;
   logic [IDX_W-1:0]       wr_idx_ff;
   logic [ENTRY_W-1:0]     wr_data_ff;
   logic                   foreign_ff;
   logic [PAGE_W-1:0]      next_cur_ff;
   logic [IDX_W-1:0]       sweep_cnt_ff;
   logic [TABLE_PAGES-1:0] zero_ff;
   logic [CNT_W-1:0]       pages_used_ff;
   logic [1:0]             status_ff;
   logic [BASE_W-1:0]      leaf_ff;

   logic [IDX_W-1:0]   level_idx;
   logic [FRAME_W-1:0] base_frame;
   logic [FRAME_W-1:0] link_frame;
   logic [FRAME_W-1:0] frame_diff;
   logic               foreign_now;
   logic [CNT_W-1:0]   arena_pages_ext;
   logic [CNT_W-1:0]   page_limit;
   logic [FRAME_W-1:0] alloc_frame;

   logic               ram_wr_en;
   logic [SLOT_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   // Table index for the current level; level 0 uses the top nine bits.
   always_comb begin
      case (level_ff)
         2'd0:    level_idx = vidx_ff[4*IDX_W-1:3*IDX_W];
         2'd1:    level_idx = vidx_ff[3*IDX_W-1:2*IDX_W];
         2'd2:    level_idx = vidx_ff[2*IDX_W-1:IDX_W];
         default: level_idx = vidx_ff[IDX_W-1:0];
      endcase
   end

   assign base_frame  = csr.arena_base[BASE_W-1:PAGE_OFS_W];
   assign link_frame  = entry_ff[ENTRY_W-1:1];
   assign frame_diff  = link_frame - base_frame;
   assign foreign_now = (link_frame < base_frame) ||
                        (frame_diff >= FRAME_W'(TABLE_PAGES));

   assign arena_pages_ext = CNT_W'(csr.arena_pages);
   assign page_limit      = (arena_pages_ext < CNT_W'(TABLE_PAGES)) ?
                            arena_pages_ext : CNT_W'(TABLE_PAGES);
   assign alloc_frame     = base_frame + FRAME_W'(pages_used_ff);

   // Store writes: a single entry, or one entry per cycle of a page zeroing sweep
   // that drops the pending entry in at its own slot.
   assign ram_wr_en   = (ctl.op == OP_WRITE_ONE) || (ctl.op == OP_SWEEP_WR);
   assign ram_wr_addr = (ctl.op == OP_SWEEP_WR) ? {wr_page_ff, sweep_cnt_ff} :
                                                  {wr_page_ff, wr_idx_ff};
   assign ram_wr_data = ((ctl.op == OP_SWEEP_WR) && (sweep_cnt_ff != wr_idx_ff)) ?
                        '0 : wr_data_ff;

   ptm_table_ram #(
      .ADDR_W (SLOT_W),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr ({cur_ff, level_idx}),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= 2'd0;
         zero_ff       <= '1;
         pages_used_ff <= CNT_W'(1);
      end else begin
         if (req_fire) begin
            phys_frame_ff <= req_data.phys_addr[BASE_W-1:PAGE_OFS_W];
            vidx_ff       <= req_data.virt_addr[PAGE_OFS_W+VIDX_W-1:PAGE_OFS_W];
            range_bad_ff  <= (|req_data.phys_addr[ADDR_W-1:BASE_W]) ||
                             (|req_data.virt_addr[ADDR_W-1:BASE_W]);
         end
         case (ctl.op)
            OP_INIT: begin
               level_ff <= 2'd0;
               cur_ff   <= '0;
            end
            OP_READ: begin
               wr_page_ff <= cur_ff;
               wr_idx_ff  <= level_idx;
            end
            OP_CAPTURE: begin
               entry_ff <= zero_ff[cur_ff] ? '0 : ram_rd_data;
            end
            OP_ALLOC: begin
               entry_ff   <= {alloc_frame, 1'b1};
               wr_data_ff <= {alloc_frame, 1'b1};
               zero_ff[pages_used_ff[PAGE_W-1:0]] <= 1'b1;
               pages_used_ff <= pages_used_ff + CNT_W'(1);
            end
            OP_LINK: begin
               foreign_ff  <= foreign_now;
               next_cur_ff <= frame_diff[PAGE_W-1:0];
            end
            OP_NEXT_LEVEL: begin
               level_ff <= level_ff + 2'd1;
               cur_ff   <= next_cur_ff;
            end
            OP_LEAF_SETUP: begin
               wr_page_ff <= cur_ff;
               wr_idx_ff  <= level_idx;
               wr_data_ff <= {phys_frame_ff, 1'b1};
            end
            OP_SWEEP_CLR: begin
               sweep_cnt_ff <= '0;
            end
            OP_SWEEP_WR: begin
               sweep_cnt_ff <= sweep_cnt_ff + IDX_W'(1);
            end
            OP_ZFLAG_CLR: begin
               zero_ff[wr_page_ff] <= 1'b0;
            end
            OP_SET_OK: begin
               status_ff <= STATUS_MAPPED;
               leaf_ff   <= {wr_data_ff[ENTRY_W-1:1], ENTRY_FLAGS};
            end
            OP_SET_RANGE: begin
               status_ff <= STATUS_RANGE_ERR;
               leaf_ff   <= '0;
            end
            OP_SET_FULL: begin
               status_ff <= STATUS_NO_TABLES;
               leaf_ff   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      flags.req_fire   = req_fire;
      flags.range_bad  = range_bad_ff;
      flags.present    = entry_ff[0];
      flags.no_room    = pages_used_ff >= page_limit;
      flags.foreign    = foreign_ff;
      flags.leaf       = (level_ff == 2'd3);
      flags.page_zero  = zero_ff[wr_page_ff];
      flags.sweep_last = &sweep_cnt_ff;
      flags.out_busy   = out_busy;
   end

   assign result.status      = status_ff;
   assign result.leaf_entry  = leaf_ff;
   assign result.tables_used = pages_used_ff[TABLES_USED_W-1:0];

endmodule

`default_nettype wire

[hdl/four_level_page_table_mapper_core.sv]
// Top level of the four-level page table mapper: channels, configuration registers and
// result register. Depends on ptm_pkg, ptm_sequencer and ptm_datapath.
//
// Usage. A request on req_data (phys_addr, virt_addr) is taken when req_valid is high and
// req_stall is low. The block maps the 4 KiB page at virt_addr[47:12] to phys_addr into a
// four-level table kept in an internal store of table pages, allocating zeroed pages from
// the arena as levels are missing. One response per request leaves on rsp_data (status,
// leaf_entry, tables_used) under rsp_valid / rsp_stall.
// Walk. A microcode sequencer drives one datapath step per cycle. An out of range request
// skips the walk, and each missing level that gets a new page adds an allocation step. The
// first write into a table page that is logically zero (the root after reset, or any
// freshly allocated page) replaces the single write step by a zeroing pass over that
// page, one entry per cycle through the store's single write port.
// Throughput. One request is worked on at a time; req_stall is low only while the
// sequencer sits in its idle step. A new request may be taken while the previous response
// still waits in the output register; its response waits until that register is free.
// Reset. Synchronous and active high. The store needs no clearing pass: every page starts
// flagged as zero, pages_used returns to one, arena_base to zero and arena_pages to 16.
// Configuration writes through csr_* are taken in any cycle outside reset and should only
// be issued while the block is idle.
`default_nettype none

module four_level_page_table_mapper_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire ptm_pkg::ptm_req_type                 req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      ptm_pkg::ptm_rsp_type                 rsp_data,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [ptm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ptm_pkg::BASE_W-1:0]           csr_wdata
);
   import ptm_pkg::*;

   ptm_ctl_type   ctl;
   ptm_flags_type flags;
   ptm_rsp_type   result;
   ptm_csr_type   csr_ff;
   ptm_csr_type   csr_in;
   logic          req_fire;
   logic          csr_fire;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   ptm_rsp_type   rsp_data_ff;

   // Requests are only taken in the idle step of the microprogram.
   assign req_stall = reset || (ctl.op != OP_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign csr_ready = !reset;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_ARENA_BASE:  csr_in.arena_base  = csr_wdata;
            CSR_ARENA_PAGES: csr_in.arena_pages = csr_wdata[ARENA_PAGES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.arena_base  <= '0;
         csr_ff.arena_pages <= ARENA_PAGES_W'(16);
      end else begin
         csr_ff <= csr_in;
      end
   end

   ptm_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   ptm_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_fire (req_fire),
      .req_data (req_data),
      .csr      (csr_ff),
      .out_busy (rsp_valid_ff),
      .flags    (flags),
      .result   (result)
   );

   // The sequencer waits for this register to drain before its emit step, so an emit
   // never overwrites a response that has not been taken.
   assign rsp_valid_in = (ctl.op == OP_EMIT) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.op == OP_EMIT) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for four_level_page_table_mapper_core: random and directed map
// requests, checked against a built-in page walk predictor. Depends on ptm_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
   import ptm_pkg::*;

   // Holds its own copy of the table store, the page counter and the arena registers.
   // Every accepted request is walked here, and the expected response is queued until the
   // block returns its response.
   class map_walk_tracker;
      localparam logic [63:0] FRAME_MASK  = 64'h01FF_FFFF_FFFF_F000;
      localparam logic [63:0] RANGE_LIMIT = 64'h0200_0000_0000_0000;
      localparam logic [63:0] PAGE_BYTES  = 64'd4096;
      localparam logic [63:0] LINK_FLAGS  = {52'd0, ENTRY_FLAGS};

      logic [63:0]              tables [TABLE_PAGES*ENTRIES_PER_TABLE];
      int unsigned              pages_used;
      logic [BASE_W-1:0]        arena_base;
      logic [ARENA_PAGES_W-1:0] arena_pages;
      ptm_rsp_type              expected_rsp[$];
      int unsigned              miss_count;

      function new();
         foreach (tables[k]) tables[k] = '0;
         pages_used  = 1;
         arena_base  = '0;
         arena_pages = 5'd16;
         miss_count  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [BASE_W-1:0] value);
         if (idx == CSR_ARENA_BASE)
            arena_base = value;
         else if (idx == CSR_ARENA_PAGES)
            arena_pages = value[ARENA_PAGES_W-1:0];
      endfunction

      // Walks the three upper levels, allocating missing tables, then writes the leaf.
      function ptm_rsp_type map_page(ptm_req_type r);
         ptm_rsp_type res;
         logic [63:0] base, lim, entry, frame, leaf;
         int unsigned cur, slot;
         bit failed;
         res    = '0;
         base   = {7'd0, arena_base} & FRAME_MASK;
         lim    = (arena_pages < TABLE_PAGES) ? 64'(arena_pages) : 64'(TABLE_PAGES);
         cur    = 0;
         failed = 1'b0;
         if (r.virt_addr >= RANGE_LIMIT || r.phys_addr >= RANGE_LIMIT) begin
            res.status = STATUS_RANGE_ERR;
         end else begin
            for (int lvl = 0; lvl < 3 && !failed; lvl++) begin
               slot  = cur * ENTRIES_PER_TABLE + int'(r.virt_addr[39 - 9*lvl +: IDX_W]);
               entry = tables[slot];
               if (!entry[0]) begin
                  if (pages_used >= lim) begin
                     failed = 1'b1;
                  end else begin
                     for (int k = 0; k < ENTRIES_PER_TABLE; k++)
                        tables[pages_used * ENTRIES_PER_TABLE + k] = '0;
                     entry = ((base + pages_used * PAGE_BYTES) & FRAME_MASK) | LINK_FLAGS;
                     tables[slot] = entry;
                     pages_used++;
                  end
               end
               if (!failed) begin
                  // A link outside the arena window counts as having no room.
                  frame = entry & FRAME_MASK;
                  if (frame < base || ((frame - base) >> 12) >= TABLE_PAGES)
                     failed = 1'b1;
                  else
                     cur = int'((frame - base) >> 12);
               end
            end
            if (failed) begin
               res.status = STATUS_NO_TABLES;
            end else begin
               leaf = (r.phys_addr & FRAME_MASK) | LINK_FLAGS;
               tables[cur * ENTRIES_PER_TABLE + int'(r.virt_addr[20:12])] = leaf;
               res.status     = STATUS_MAPPED;
               res.leaf_entry = leaf[BASE_W-1:0];
            end
         end
         res.tables_used = pages_used[TABLES_USED_W-1:0];
         return res;
      endfunction

      function void take_request(ptm_req_type r);
         expected_rsp.push_back(map_page(r));
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void report_miss(string what, ptm_rsp_type want, ptm_rsp_type got);
         miss_count++;
         if (miss_count <= 10)
            $display({"%0t ns: %s: expected status=%0d leaf=%h used=%0d, ",
                      "got status=%0d leaf=%h used=%0d"},
                     $realtime, what, want.status, want.leaf_entry, want.tables_used,
                     got.status, got.leaf_entry, got.tables_used);
      endfunction

      function void check_response(ptm_rsp_type got);
         ptm_rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_miss("response with no request outstanding", '0, got);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status || got.leaf_entry !== want.leaf_entry ||
             got.tables_used !== want.tables_used)
            report_miss("wrong response", want, got);
      endfunction
   endclass

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ptm_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ptm_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [BASE_W-1:0]     csr_wdata = '0;

   map_walk_tracker tracker = new();

   // Sender burst bookkeeping, carried across phases.
   int unsigned burst_left = 0;

   four_level_page_table_mapper_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Both handshakes are sampled at the clock edge with the values that stood before it,
   // so the order of processes within the edge's time step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.take_request(req_data);
         if (rsp_valid && !rsp_stall)
            tracker.check_response(rsp_data);
      end
   end

   // The response side switches between stall patterns at random intervals: open,
   // occasional stalls, heavy random stalls, and a fixed duty cycle.
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
         default:     rsp_stall <= ((stall_left % 8) < 5);
      endcase
   end

   // Builds a virtual address from its four 9-bit table indexes.
   function automatic logic [63:0] make_virt(logic [8:0] l4, logic [8:0] l3, logic [8:0] l2,
                                             logic [8:0] l1);
      return {16'd0, l4, l3, l2, l1, 12'd0};
   endfunction

   // Most requests reuse a small set of upper-level paths, so that once the arena is used up
   // the walks still reach the leaf level. A few are fully random, and a few carry an
   // address at or above the 57-bit limit.
   function automatic ptm_req_type random_map_request();
      ptm_req_type r;
      int unsigned kind;
      logic [8:0]  l4;
      kind = $urandom_range(0, 99);
      r.phys_addr = {$urandom, $urandom};
      r.virt_addr = {$urandom, $urandom};
      case ($urandom_range(0, 2))
         0:       l4 = 9'h000;
         1:       l4 = 9'h1FF;
         default: l4 = 9'h0A5;
      endcase
      if (kind < 85) begin
         r.virt_addr[47:39] = l4;
         r.virt_addr[38:30] = $urandom_range(0, 1) ? 9'h000 : 9'h1FF;
         r.virt_addr[29:21] = $urandom_range(0, 1) ? 9'h000 : 9'h155;
      end
      if (kind >= 8)
         r.phys_addr[63:57] = '0;
      if (kind >= 4)
         r.virt_addr[63:57] = '0;
      return r;
   endfunction

   // Presents one request and returns at the edge where it is taken. Valid is left high so
   // that a following request goes out back to back.
   task automatic send_map(input ptm_req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_pair(input logic [63:0] phys, input logic [63:0] virt);
      ptm_req_type r;
      r.phys_addr = phys;
      r.virt_addr = virt;
      send_map(r);
   endtask

   // Random requests in bursts of random length, with random gaps between bursts.
   task automatic send_random(input int unsigned count);
      int unsigned gap;
      for (int unsigned i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 20);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         send_map(random_map_request());
         burst_left--;
      end
   endtask

   // Lowers valid and waits until every expected response has come back. The first edge
   // lets the last accepted request reach the tracker.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // Writes both arena registers back to back, only while the block is idle.
   task automatic program_arena(input logic [BASE_W-1:0] base,
                                input logic [BASE_W-1:0] pages);
      csr_valid <= 1'b1;
      csr_index <= CSR_ARENA_BASE;
      csr_wdata <= base;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      tracker.set_register(CSR_ARENA_BASE, base);
      csr_index <= CSR_ARENA_PAGES;
      csr_wdata <= pages;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      tracker.set_register(CSR_ARENA_PAGES, pages);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero arena: only the root exists, so any missing level reports no tables. Range
      // errors are checked here too, right at the 57-bit boundary and with every bit set.
      program_arena(57'd0, 57'd0);
      send_pair(64'd0, 64'd0);
      send_pair(64'h0200_0000_0000_0000, 64'd0);
      send_pair(64'd0, 64'h0200_0000_0000_0000);
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      drain_responses();

      // Small arena of four pages with stray low bits in the base: the first path uses up
      // the arena, then new paths run out at the top and at the second level.
      program_arena(57'h0AB_CFFF, 57'd4);
      send_pair(64'h01FF_FFFF_FFFF_FFFF, make_virt(9'h000, 9'h000, 9'h000, 9'h000));
      send_pair(64'h0000_1234_5678_9ABC,
                make_virt(9'h000, 9'h000, 9'h000, 9'h1FF) | 64'h01FF_0000_0000_0ABC);
      send_pair(64'h0000_0000_0000_1000, make_virt(9'h1FF, 9'h000, 9'h000, 9'h000));
      send_pair(64'h0000_0000_0000_2000, make_virt(9'h000, 9'h005, 9'h000, 9'h000));
      send_pair(64'd0, 64'h01FF_FFFF_FFFF_FFFF);
      drain_responses();

      // Full arena again: the top path is built, then its leaf is overwritten.
      program_arena(57'h0AB_000, 57'd16);
      send_pair(64'h0000_0000_0000_0000, 64'h01FF_FFFF_FFFF_FFFF);
      send_pair(64'h00AA_5555_AAAA_5FFF, 64'h01FF_FFFF_FFFF_FFFF);
      drain_responses();

      // Base moved to its highest value: existing links become foreign, and a fresh link
      // wraps around the address mask and is foreign as well, though it stays written.
      program_arena(57'h1FF_FFFF_FFFF_F000, 57'd16);
      send_pair(64'h0000_0000_0000_5000, make_virt(9'h000, 9'h000, 9'h000, 9'h001));
      send_pair(64'h0000_0000_0000_6000, make_virt(9'h0A5, 9'h000, 9'h000, 9'h000));
      drain_responses();

      // Random phases over several arena settings: back to the original window, a zero
      // base with the page count above the store size, a window shifted by one page, and
      // a one-page arena in which only existing paths can still map.
      program_arena(57'h0AB_000, 57'd16);
      send_random(200);
      drain_responses();

      program_arena(57'd0, 57'd31);
      send_random(50);
      drain_responses();

      program_arena(57'h0AC_000, 57'd16);
      send_random(100);
      drain_responses();

      program_arena(57'h0AB_5A5, 57'd1);
      send_random(150);
      drain_responses();

      // Leave room for any stray response before judging the run.
      repeat (64) @(posedge clock);
      if (tracker.miss_count == 0 && tracker.pending() == 0)
         $display("four_level_page_table_mapper_core: match");
      else
         $display("four_level_page_table_mapper_core: mismatch");
      $finish;
   end

   // A correct run needs only a fraction of this.
   initial begin
      #3_000_000;
      $display("four_level_page_table_mapper_core: mismatch");
      $finish;
   end

endmodule

[sim.f]
hdl/ptm_pkg.sv
hdl/ptm_table_ram.sv
hdl/ptm_sequencer.sv
hdl/ptm_datapath.sv
hdl/four_level_page_table_mapper_core.sv
sim/testbench.sv
